// File: src/chcal_pkg.sv
// Shared types, constants and the arctangent table for the compass heading block.
// No dependencies; every other file of the block imports this package.
package chcal_pkg;

  localparam int SAMPLE_W    = 13;
  localparam int DIFF_W      = 14;
  localparam int VEC_W       = 26;
  localparam int ANG_W       = 32;
  localparam int HEAD_W      = 13;
  localparam int SUM_W       = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W      = $clog2(CORDIC_STEPS);
  localparam int ANGLE_FRACTION_BITS = 4;
  localparam int ACC_BITS    = 20;
  localparam int PRE_SHIFT   = 8;

  localparam int FULL_TURN   = 360 << ANGLE_FRACTION_BITS;
  localparam int HALF_TURN   = 180 << ANGLE_FRACTION_BITS;

  localparam logic signed [ANG_W-1:0] ACC_FULL = ANG_W'(360 << ACC_BITS);
  localparam logic signed [ANG_W-1:0] ACC_HALF = ANG_W'(180 << ACC_BITS);
  localparam int ROUND_SHIFT = ACC_BITS - ANGLE_FRACTION_BITS;

  localparam logic [2:0] OP_MEASURE   = 3'd0;
  localparam logic [2:0] OP_CAL_START = 3'd1;
  localparam logic [2:0] OP_CAL_SAMPLE = 3'd2;
  localparam logic [2:0] OP_CAL_FINISH = 3'd3;
  localparam logic [2:0] OP_CAPTURE   = 3'd4;

  localparam logic REG_DECLINATION = 1'b0;
  localparam logic REG_THRESHOLD   = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [DIFF_W-1:0]   diff_t;
  typedef logic [HEAD_W-1:0]          head_t;

  // Arctangent of 2^-i in degrees with ACC_BITS fraction bits.
  function automatic logic [ANG_W-1:0] atan_lut(input logic [4:0] idx);
    logic [ANG_W-1:0] v;
    case (idx)
      5'd0:  v = 32'd47185920;
      5'd1:  v = 32'd27855475;
      5'd2:  v = 32'd14718068;
      5'd3:  v = 32'd7471121;
      5'd4:  v = 32'd3750058;
      5'd5:  v = 32'd1876857;
      5'd6:  v = 32'd938658;
      5'd7:  v = 32'd469357;
      5'd8:  v = 32'd234682;
      5'd9:  v = 32'd117342;
      5'd10: v = 32'd58671;
      5'd11: v = 32'd29335;
      5'd12: v = 32'd14668;
      5'd13: v = 32'd7334;
      5'd14: v = 32'd3667;
      5'd15: v = 32'd1833;
      5'd16: v = 32'd917;
      5'd17: v = 32'd458;
      5'd18: v = 32'd229;
      5'd19: v = 32'd115;
      5'd20: v = 32'd57;
      5'd21: v = 32'd29;
      5'd22: v = 32'd14;
      5'd23: v = 32'd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: src/chcal_cordic.sv
// Iterative vectoring CORDIC: one rotation step per cycle, angle in output grid units.
// Depends on chcal_pkg.
module chcal_cordic (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  chcal_pkg::diff_t dx,
  input  chcal_pkg::diff_t dy,
  output logic            done,
  output chcal_pkg::head_t angle
);
  import chcal_pkg::*;

  logic                     busy_r, busy_nxt;
  logic                     fin_r, fin_nxt;
  logic                     done_r, done_nxt;
  logic                     zero_r, zero_nxt;
  logic [STEP_W-1:0]        cnt_r, cnt_nxt;
  logic signed [VEC_W-1:0]  x_r, x_nxt, y_r, y_nxt;
  logic signed [ANG_W-1:0]  z_r, z_nxt;
  head_t                    angle_r, angle_nxt;

  logic signed [VEC_W-1:0]  x0, y0, xs, ys;
  logic signed [ANG_W-1:0]  zf, zr, at;

  always_comb begin
    x0 = VEC_W'(dx) <<< PRE_SHIFT;
    y0 = VEC_W'(dy) <<< PRE_SHIFT;
    xs = x_r >>> cnt_r;
    ys = y_r >>> cnt_r;
    at = atan_lut(5'(cnt_r));
    zf = (z_r < 0) ? z_r + ACC_FULL : z_r;
    zr = (zf + ANG_W'(1 << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;

    busy_nxt  = busy_r;
    fin_nxt   = 1'b0;
    done_nxt  = 1'b0;
    zero_nxt  = zero_r;
    cnt_nxt   = cnt_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    angle_nxt = angle_r;

    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      zero_nxt = (dx == '0) && (dy == '0);
      if (dx < 0) begin
        x_nxt = -x0;
        y_nxt = -y0;
        z_nxt = ACC_HALF;
      end else begin
        x_nxt = x0;
        y_nxt = y0;
        z_nxt = '0;
      end
    end else if (busy_r) begin
      if (y_r >= 0) begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + at;
      end else begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - at;
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == STEP_W'(CORDIC_STEPS - 1)) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end else if (fin_r) begin
      angle_nxt = zero_r ? '0 : zr[HEAD_W-1:0];
      done_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      done_r <= done_nxt;
    end
    zero_r  <= zero_nxt;
    cnt_r   <= cnt_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    z_r     <= z_nxt;
    angle_r <= angle_nxt;
  end

  assign done  = done_r;
  assign angle = angle_r;

endmodule

// File: src/chcal_cal.sv
// Hard-iron calibration: per-axis min/max tracking and offset derivation.
// Depends on chcal_pkg.
module chcal_cal (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 strobe,
  input  logic [2:0]           op,
  input  chcal_pkg::sample_t   smp [3],
  input  logic [12:0]          threshold,
  output chcal_pkg::sample_t   offset [3],
  output chcal_pkg::sample_t   offset_nxt_o [3]
);
  import chcal_pkg::*;

  sample_t max_r [3], max_nxt [3];
  sample_t min_r [3], min_nxt [3];
  sample_t off_r [3], off_nxt [3];

  logic signed [DIFF_W-1:0] span, sum, half;
  logic [DIFF_W-1:0]        mag;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      max_nxt[k] = max_r[k];
      min_nxt[k] = min_r[k];
      off_nxt[k] = off_r[k];
      span = DIFF_W'(max_r[k]) - DIFF_W'(min_r[k]);
      mag  = (span < 0) ? DIFF_W'(-span) : DIFF_W'(span);
      sum  = DIFF_W'(max_r[k]) + DIFF_W'(min_r[k]);
      // Halve toward zero: bump negative sums by one before the shift.
      half = (sum + DIFF_W'(sum < 0)) >>> 1;
      if (strobe) begin
        case (op)
          OP_CAL_START: begin
            max_nxt[k] = smp[k];
            min_nxt[k] = smp[k];
            off_nxt[k] = '0;
          end
          OP_CAL_SAMPLE: begin
            if (smp[k] > max_r[k]) max_nxt[k] = smp[k];
            if (smp[k] < min_r[k]) min_nxt[k] = smp[k];
          end
          OP_CAL_FINISH: begin
            off_nxt[k] = (mag > DIFF_W'(threshold)) ? half[SAMPLE_W-1:0] : '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (!rst_n) begin
        max_r[k] <= '0;
        min_r[k] <= '0;
        off_r[k] <= '0;
      end else begin
        max_r[k] <= max_nxt[k];
        min_r[k] <= min_nxt[k];
        off_r[k] <= off_nxt[k];
      end
    end
  end

  assign offset       = off_r;
  assign offset_nxt_o = off_nxt;

endmodule

// File: src/compass_heading_with_offset_calibration.sv
// Top level of the compass heading block with hard-iron offset calibration.
// Depends on chcal_pkg, chcal_cordic and chcal_cal.
//
// Usage: one item on the in_ channel carries an opcode and a three-axis
// magnetometer sample. For each item the block returns exactly one item on
// the out_ channel with the corrected heading (1/16 degree, 0 to 5760), the
// three axis offsets in effect after the item, and a flag that is set when
// the item captured a new heading reference.
// The heading uses the offsets and reference as they stood before the item.
// Calibration updates happen in the cycle the item is accepted.
// Sequence: the CORDIC is loaded at the accepting edge, then come 16 rotation
// steps, the rounding of the angle, the addition of declination and reference,
// up to two wrap corrections and the load of the output register, which sets
// out_tvalid; the load waits while the output register holds an unaccepted
// result. A new item is taken only once the previous one has reached the
// output register, so the block does not take an item before it is through
// with the last one.
// When the receiver stalls, the finished result waits in the output register
// and the next item is still accepted and processed; it then waits in the
// wrap stage until the output register frees.
// Reset (synchronous, rst_n low) clears min/max, offsets and reference, sets
// the declination to 85 and the span threshold to 0. Configuration writes
// are always accepted on the cfg_ port and must be made while idle.
module compass_heading_with_offset_calibration (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: opcode[2:0], mag_x[15:3], mag_y[28:16], mag_z[41:29], zeros above
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,
  // out_tdata: heading[12:0], offset_x_out[25:13], offset_y_out[38:26],
  // offset_z_out[51:39], reference_taken[52], zeros above
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data
);
  import chcal_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CORD = 2'd1;
  localparam logic [1:0] S_WRAP = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [2:0]  op_r, op_nxt;
  logic signed [SUM_W-1:0] h_r, h_nxt;
  sample_t     decl_r, decl_nxt;
  logic [12:0] thr_r, thr_nxt;
  sample_t     ref_r, ref_nxt;
  sample_t     pend_off_r [3], pend_off_nxt [3];
  logic        ov_r, ov_nxt;
  logic [55:0] od_r, od_nxt;

  logic        accept, cord_done;
  sample_t     smp [3];
  sample_t     off [3], off_after [3];
  diff_t       dx, dy;
  head_t       angle;
  logic        taken;

  assign smp[0] = in_tdata[15:3];
  assign smp[1] = in_tdata[28:16];
  assign smp[2] = in_tdata[41:29];
  assign accept = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // Differences use the offsets held before this item.
  assign dx = DIFF_W'(smp[0]) - DIFF_W'(off[0]);
  assign dy = DIFF_W'(smp[1]) - DIFF_W'(off[1]);

  chcal_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .dx    (dx),
    .dy    (dy),
    .done  (cord_done),
    .angle (angle)
  );

  chcal_cal u_cal (
    .clk          (clk),
    .rst_n        (rst_n),
    .strobe       (accept),
    .op           (in_tdata[2:0]),
    .smp          (smp),
    .threshold    (thr_r),
    .offset       (off),
    .offset_nxt_o (off_after)
  );

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    h_nxt        = h_r;
    decl_nxt     = decl_r;
    thr_nxt      = thr_r;
    ref_nxt      = ref_r;
    pend_off_nxt = pend_off_r;
    ov_nxt       = ov_r;
    od_nxt       = od_r;
    taken        = (op_r == OP_CAPTURE);

    if (ov_r && out_tready) ov_nxt = 1'b0;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DECLINATION: decl_nxt = cfg_data;
        REG_THRESHOLD:   thr_nxt  = cfg_data;
        default: begin
        end
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt       = in_tdata[2:0];
          pend_off_nxt = off_after;
          state_nxt    = S_CORD;
        end
      end
      S_CORD: begin
        if (cord_done) begin
          h_nxt = SUM_W'(angle) + SUM_W'(decl_r) - SUM_W'(ref_r);
          state_nxt = S_WRAP;
        end
      end
      S_WRAP: begin
        // One correction per cycle; at most two are ever needed.
        if (h_r > SUM_W'(FULL_TURN)) begin
          h_nxt = h_r - SUM_W'(FULL_TURN);
        end else if (h_r < 0) begin
          h_nxt = h_r + SUM_W'(FULL_TURN);
        end else if (!ov_r || out_tready) begin
          ov_nxt = 1'b1;
          od_nxt = {3'b000, taken, pend_off_r[2], pend_off_r[1], pend_off_r[0],
                    h_r[HEAD_W-1:0]};
          if (taken) ref_nxt = SAMPLE_W'(h_r - SUM_W'(HALF_TURN));
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      decl_r  <= SAMPLE_W'(85);
      thr_r   <= '0;
      ref_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      decl_r  <= decl_nxt;
      thr_r   <= thr_nxt;
      ref_r   <= ref_nxt;
      ov_r    <= ov_nxt;
    end
    op_r       <= op_nxt;
    h_r        <= h_nxt;
    pend_off_r <= pend_off_nxt;
    od_r       <= od_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

endmodule

// File: dv/tb_compass_heading_with_offset_calibration.sv
`timescale 1ns / 100ps
// Self-checking testbench for the compass heading block with offset calibration.
// Depends on chcal_pkg and the RTL top level; a built-in heading predictor checks every result.
module tb_compass_heading_with_offset_calibration;
  import chcal_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // in_tdata: opcode, mag_x, mag_y, mag_z from the lowest bit up.
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  // out_tdata: heading, offset_x_out, offset_y_out, offset_z_out, reference_taken.
  logic [55:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [12:0] cfg_data;

  compass_heading_with_offset_calibration dut (.*);

  // One result item as the block packs it.
  typedef struct packed {
    logic       taken;
    sample_t    off_z;
    sample_t    off_y;
    sample_t    off_x;
    head_t      heading;
  } heading_result_t;

  // One directed row. A check value of -1 means the predictor alone decides.
  typedef struct {
    logic [2:0] op;
    int         mx;
    int         my;
    int         mz;
    int         want_heading;
  } sample_row_t;

  heading_result_t pending_headings[$];

  // Predictor state, kept in plain ints.
  int          trk_max[3];
  int          trk_min[3];
  int          trk_off[3];
  int          ref_heading;
  int          decl;
  int          span_limit;

  int          errors;
  int          fixed_heading[$];
  longint      cycles;
  int          send_idle_pct;
  int          recv_idle_pct;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Arithmetic shift right with rounding toward minus infinity.
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  // Raw CORDIC angle in 1/16 degree, 0 to 5760.
  function automatic int cordic_heading(int dx, int dy);
    longint x, y, z, xs, ys;
    if (dx == 0 && dy == 0) return 0;
    x = longint'(dx) * 256;
    y = longint'(dy) * 256;
    z = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = longint'(180) << ACC_BITS;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = floor_shift(x, i);
      ys = floor_shift(y, i);
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(atan_lut(5'(i)));
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(atan_lut(5'(i)));
      end
    end
    if (z < 0) z = z + (longint'(360) << ACC_BITS);
    return int'((z * 16 + (longint'(1) << (ACC_BITS - 1))) >>> ACC_BITS);
  endfunction

  // Advances the predictor by one item and returns what the block should send.
  function automatic heading_result_t predict_heading(logic [2:0] op, int s[3]);
    heading_result_t r;
    int h, span;
    h = cordic_heading(s[0] - trk_off[0], s[1] - trk_off[1]) + decl - ref_heading;
    while (h > FULL_TURN) h -= FULL_TURN;
    while (h < 0) h += FULL_TURN;
    r.taken = 1'b0;
    case (op)
      OP_CAL_START: begin
        for (int k = 0; k < 3; k++) begin
          trk_max[k] = s[k];
          trk_min[k] = s[k];
          trk_off[k] = 0;
        end
      end
      OP_CAL_SAMPLE: begin
        for (int k = 0; k < 3; k++) begin
          if (s[k] > trk_max[k]) trk_max[k] = s[k];
          if (s[k] < trk_min[k]) trk_min[k] = s[k];
        end
      end
      OP_CAL_FINISH: begin
        for (int k = 0; k < 3; k++) begin
          span = trk_max[k] - trk_min[k];
          if (span < 0) span = -span;
          // Integer division in SystemVerilog truncates toward zero, like the block.
          trk_off[k] = (span > span_limit) ? (trk_max[k] + trk_min[k]) / 2 : 0;
        end
      end
      OP_CAPTURE: begin
        ref_heading = h - HALF_TURN;
        r.taken = 1'b1;
      end
      default: ;
    endcase
    r.heading = head_t'(h);
    r.off_x = sample_t'(trk_off[0]);
    r.off_y = sample_t'(trk_off[1]);
    r.off_z = sample_t'(trk_off[2]);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Result checker: compares every accepted result item with the oldest expectation.
  always @(posedge clk) begin
    heading_result_t got, want;
    int fh;
    if (rst_n && out_tvalid && out_tready) begin
      got = heading_result_t'(out_tdata[52:0]);
      if (pending_headings.size() == 0) begin
        report_mismatch("unexpected item", int'(got.heading), -1);
      end else begin
        want = pending_headings.pop_front();
        fh = fixed_heading.pop_front();
        if (got.heading !== want.heading)
          report_mismatch("heading", int'(got.heading), int'(want.heading));
        if (fh >= 0 && int'(want.heading) != fh)
          report_mismatch("predicted heading", int'(want.heading), fh);
        if (got.off_x !== want.off_x) report_mismatch("offset_x", got.off_x, want.off_x);
        if (got.off_y !== want.off_y) report_mismatch("offset_y", got.off_y, want.off_y);
        if (got.off_z !== want.off_z) report_mismatch("offset_z", got.off_z, want.off_z);
        if (got.taken !== want.taken) report_mismatch("reference_taken", got.taken, want.taken);
      end
      if (out_tdata[55:53] !== 3'b000) report_mismatch("pad bits", out_tdata[55:53], 0);
    end
  end

  // The receiver stalls at the rate of the current phase.
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: ends the run with a fail if it goes on too long.
  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("compass_heading_with_offset_calibration regression: fail");
      $finish;
    end
  end

  // Drives one item and updates the predictor when it is accepted.
  task automatic send_item(logic [2:0] op, int mx, int my, int mz, int fixed_h);
    int s[3];
    s[0] = mx;
    s[1] = my;
    s[2] = mz;
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, 13'(mz), 13'(my), 13'(mx), op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_headings.push_back(predict_heading(op, s));
    fixed_heading.push_back(fixed_h);
    in_tvalid <= 1'b0;
    // The block takes no new item until the last one has reached the output register, so this gap costs nothing.
    @(posedge clk);
  endtask

  task automatic drain_results();
    while (pending_headings.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // Writes one register once the block has gone idle.
  task automatic write_register(logic idx, int value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 13'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_DECLINATION) decl = value;
    else span_limit = value;
  endtask

  function automatic int rand_sample();
    case ($urandom_range(7))
      0: return -4096;
      1: return 4095;
      2: return $urandom_range(16) - 8;
      default: return int'($urandom_range(8191)) - 4096;
    endcase
  endfunction

  // A calibration run: start, a few samples around a random center, finish.
  task automatic calibration_run();
    int cx, cy, cz, n;
    cx = int'($urandom_range(1000)) - 500;
    cy = int'($urandom_range(1000)) - 500;
    cz = int'($urandom_range(1000)) - 500;
    n = $urandom_range(6, 1);
    send_item(OP_CAL_START, cx, cy, cz, -1);
    repeat (n) send_item(OP_CAL_SAMPLE, cx + int'($urandom_range(3000)) - 1500,
                         cy + int'($urandom_range(3000)) - 1500,
                         cz + int'($urandom_range(3000)) - 1500, -1);
    send_item(OP_CAL_FINISH, rand_sample(), rand_sample(), rand_sample(), -1);
  endtask

  task automatic random_phase(int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(9) < 3) begin
        calibration_run();
        sent += 4;
      end else begin
        // Opcodes above capture are unused and behave as measure.
        send_item(3'($urandom_range(7)), rand_sample(), rand_sample(), rand_sample(), -1);
        sent++;
      end
    end
  endtask

  sample_row_t directed_rows[$];

  initial begin
    errors = 0;
    cycles = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    decl = 85;
    span_limit = 0;
    ref_heading = 0;
    for (int k = 0; k < 3; k++) begin
      trk_max[k] = 0;
      trk_min[k] = 0;
      trk_off[k] = 0;
    end
    send_idle_pct = 25;
    recv_idle_pct = 47;
    // Directed rows: zero vector, the four axes, field extremes, every opcode,
    // finish without a start, a capture and the unused opcodes.
    directed_rows = '{
      '{OP_MEASURE, 0, 0, 0, 85},
      '{OP_MEASURE, 100, 0, 0, 85},
      '{OP_MEASURE, 0, 100, 0, 1525},
      '{OP_MEASURE, -100, 0, 0, 2965},
      '{OP_MEASURE, 0, -100, 0, 4405},
      '{OP_MEASURE, 4095, 4095, 4095, -1},
      '{OP_MEASURE, -4096, -4096, -4096, -1},
      '{OP_MEASURE, -4096, 4095, 0, -1},
      '{OP_MEASURE, 1, -1, 0, -1},
      '{OP_CAL_FINISH, 0, 0, 0, -1},
      '{OP_CAL_START, 300, -200, 50, -1},
      '{OP_CAL_SAMPLE, 4095, -4096, 4095, -1},
      '{OP_CAL_SAMPLE, -4096, 4095, -4096, -1},
      '{OP_CAL_SAMPLE, 10, 20, 30, -1},
      '{OP_CAL_FINISH, 7, 7, 7, -1},
      '{OP_MEASURE, 500, 500, 0, -1},
      '{OP_CAPTURE, 500, 0, 0, -1},
      '{OP_MEASURE, 500, 0, 0, -1},
      '{3'd5, 123, -456, 789, -1},
      '{3'd6, -1, 1, -1, -1},
      '{3'd7, 0, 0, 0, -1},
      '{OP_CAL_START, 0, 0, 0, -1},
      '{OP_CAL_FINISH, 0, 0, 0, -1}
    };
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].mx, directed_rows[i].my,
                directed_rows[i].mz, directed_rows[i].want_heading);

    // Extreme register settings, then ordinary ones.
    write_register(REG_DECLINATION, 2880);
    write_register(REG_THRESHOLD, 8191);
    random_phase(150);
    write_register(REG_DECLINATION, -2880);
    write_register(REG_THRESHOLD, 0);
    random_phase(150);

    send_idle_pct = 47;
    recv_idle_pct = 25;
    write_register(REG_DECLINATION, -4096);
    write_register(REG_THRESHOLD, 1500);
    random_phase(200);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_register(REG_DECLINATION, 4095);
    write_register(REG_THRESHOLD, 3000);
    random_phase(150);
    write_register(REG_DECLINATION, 85);
    write_register(REG_THRESHOLD, 0);
    random_phase(150);

    drain_results();
    if (errors == 0) begin
      $display("compass_heading_with_offset_calibration regression: pass");
    end else begin
      $display("compass_heading_with_offset_calibration regression: fail");
    end
    $finish;
  end

endmodule
